@@ rtl/vertex_normal_accumulator_defines.svh @@
// Assertion macros for the vertex normal accumulator.
`ifndef VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VNA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vna check failed");
`define VNA_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("vna reset check failed");
`endif

@@ rtl/vna_pkg.sv @@
package vna_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam int IDX_W = 10;
  localparam int FLD_W = 16;
  localparam int SUM_W = 48;
  localparam int VERTEX_CAPACITY = 1024;
  localparam int COORD_BITS = 16;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              command;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic signed [FLD_W-1:0] pos_x;
    logic signed [FLD_W-1:0] pos_y;
    logic signed [FLD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FLD_W-1:0] normal_x;
    logic signed [FLD_W-1:0] normal_y;
    logic signed [FLD_W-1:0] normal_z;
    logic                    zero_sum;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  sx;
    logic [SUM_W-1:0]  sy;
    logic [SUM_W-1:0]  sz;
  } norm_req_t;
endpackage

@@ rtl/vna_normalize.sv @@
module vna_normalize import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  norm_req_t req,
  output logic      done,
  output out_item_t res
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MAX = 4'd1, S_SHIFT = 4'd2, S_SQ = 4'd3,
                         S_SQ2 = 4'd4, S_SQRT = 4'd5, S_DIV = 4'd6, S_OUT = 4'd7;
  logic [3:0] st_r, st_nxt;
  logic [2:0] neg_r;
  logic [SUM_W-1:0] mx_r, my_r, mz_r, m_r;
  logic [63:0] q_r, rt_r, bit_r;
  logic [30:0] len_r;
  logic [1:0] comp_r;
  logic [47:0] num_r;
  logic [16:0] quo_r;
  logic [5:0] cnt_r;
  logic [47:0] rem_r;
  logic [16:0] qx_r, qy_r, qz_r;
  logic [61:0] sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0] ax, ay, az;
  logic [63:0] sum_rb;
  logic [48:0] rem_try;
  logic [63:0] rb;

  assign ax = req.sx[SUM_W-1] ? -req.sx : req.sx;
  assign ay = req.sy[SUM_W-1] ? -req.sy : req.sy;
  assign az = req.sz[SUM_W-1] ? -req.sz : req.sz;
  assign rb = rt_r + bit_r;
  assign rem_try = {rem_r, num_r[47]} - {17'd0, len_r, 1'b0};
  assign sum_rb = {2'b0, sqx_r} + {2'b0, sqy_r} + {2'b0, sqz_r};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (req.start) st_nxt = S_MAX;
      S_MAX: st_nxt = (m_r == '0) ? S_OUT : S_SHIFT;
      S_SHIFT: if (m_r[SUM_W-1:30] == '0 && m_r[29]) st_nxt = S_SQ;
      S_SQ: st_nxt = S_SQ2;
      S_SQ2: st_nxt = S_SQRT;
      S_SQRT: if (bit_r == '0) st_nxt = S_DIV;
      S_DIV: if (cnt_r == 6'd0 && comp_r == 2'd2) st_nxt = S_OUT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    done <= rst_n && (st_r == S_OUT);
    case (st_r)
      S_IDLE: begin
        mx_r <= ax; my_r <= ay; mz_r <= az;
        neg_r <= {req.sx[SUM_W-1], req.sy[SUM_W-1], req.sz[SUM_W-1]};
        m_r <= (ax > ay) ? ((ax > az) ? ax : az) : ((ay > az) ? ay : az);
        quo_r <= '0;
      end
      S_SHIFT: begin
        if (m_r[SUM_W-1:30] != '0) begin
          m_r <= m_r >> 1; mx_r <= mx_r >> 1; my_r <= my_r >> 1; mz_r <= mz_r >> 1;
        end else if (!m_r[29]) begin
          m_r <= m_r << 1; mx_r <= mx_r << 1; my_r <= my_r << 1; mz_r <= mz_r << 1;
        end
      end
      S_SQ: begin
        sqx_r <= mx_r[30:0] * mx_r[30:0];
        sqy_r <= my_r[30:0] * my_r[30:0];
        sqz_r <= mz_r[30:0] * mz_r[30:0];
      end
      S_SQ2: begin
        q_r <= sum_rb; rt_r <= '0; bit_r <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (bit_r != '0) begin
          if (bit_r > q_r && rt_r == '0) begin
            bit_r <= bit_r >> 2;
          end else begin
            if (q_r >= rb) begin
              q_r <= q_r - rb; rt_r <= (rt_r >> 1) + bit_r;
            end else begin
              rt_r <= rt_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end else begin
          len_r <= rt_r[30:0];
          comp_r <= 2'd0; cnt_r <= 6'd47; rem_r <= '0;
          num_r <= {2'b0, mx_r[30:0], 15'd0} + {17'd0, rt_r[30:0]};
        end
      end
      S_DIV: begin
        if (cnt_r == 6'd0) begin
          case (comp_r)
            2'd0: qx_r <= rem_try[48] ? {quo_r[15:0], 1'b0} : {quo_r[15:0], 1'b1};
            2'd1: qy_r <= rem_try[48] ? {quo_r[15:0], 1'b0} : {quo_r[15:0], 1'b1};
            default: qz_r <= rem_try[48] ? {quo_r[15:0], 1'b0} : {quo_r[15:0], 1'b1};
          endcase
          comp_r <= comp_r + 2'd1; cnt_r <= 6'd47; rem_r <= '0;
          num_r <= {2'b0, (comp_r == 2'd0 ? my_r[30:0] : mz_r[30:0]), 15'd0}
                   + {17'd0, len_r};
        end else begin
          if (!rem_try[48]) begin
            rem_r <= rem_try[47:0]; quo_r <= {quo_r[15:0], 1'b1};
          end else begin
            rem_r <= {rem_r[46:0], num_r[47]}; quo_r <= {quo_r[15:0], 1'b0};
          end
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 6'd1;
        end
      end
      S_OUT: begin
        res.zero_sum <= (m_r == '0);
        res.normal_x <= (m_r == '0) ? '0 : (neg_r[2] ? -qx_r[15:0] : qx_r[15:0]);
        res.normal_y <= (m_r == '0) ? '0 : (neg_r[1] ? -qy_r[15:0] : qy_r[15:0]);
        res.normal_z <= (m_r == '0) ? '0 : (neg_r[0] ? -qz_r[15:0] : qz_r[15:0]);
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/vertex_normal_accumulator.sv @@
// Vertex normal accumulator. One input channel (in_valid/in_ready/in_data) takes
// commands: write a vertex position, add a triangle, or read a vertex normal.
// Only a read produces a result, on out_valid/out_ready/out_data.
// Items are processed one at a time. A triangle takes three position reads, a cross
// product and three sum read-modify-writes through the single sum memory port.
// For a read, out_valid rises after the one-bit-per-cycle normalizing shift, the
// square root and the three divisions; a zero sum skips all three of these steps.
// After reset a clearing pass zeroes the sum memory; no input transfer is
// accepted during it.
// A result waits in the output register while the receiver stalls; the block
// takes no new item until it has been taken.
// Positions of vertices never written read as undefined values.
`include "vertex_normal_accumulator_defines.svh"
module vertex_normal_accumulator import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam int AW = (VERTEX_CAPACITY > 1) ? $clog2(VERTEX_CAPACITY) : 1;
  localparam int CW = COORD_BITS;
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RA = 4'd2, S_RB = 4'd3,
                         S_RC = 4'd4, S_SUB = 4'd5, S_MUL = 4'd6, S_CRS = 4'd7,
                         S_RD = 4'd8, S_WR = 4'd9, S_NRM = 4'd10, S_OUT = 4'd11,
                         S_RDW = 4'd12, S_WCL = 4'd13;

  logic [3*CW-1:0] pos_mem [VERTEX_CAPACITY];
  logic [3*SUM_W-1:0] sum_mem [VERTEX_CAPACITY];
  logic [3*CW-1:0] pos_q;
  logic [3*SUM_W-1:0] sum_q;

  logic [3:0] st_r;
  logic [16:0] clr_r;
  in_item_t it_r;
  logic [1:0] k_r;
  logic signed [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [CW:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [2*CW+1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [SUM_W-1:0] nx_r, ny_r, nz_r;
  logic pos_re, sum_re, sum_we;
  logic [AW-1:0] pos_ra, sum_a;
  logic [3*SUM_W-1:0] sum_wd;
  logic [AW-1:0] corner;
  norm_req_t nreq;
  logic ndone;
  out_item_t nres;

  function automatic logic in_rng(input logic [IDX_W-1:0] i);
    return 32'(i) < VERTEX_CAPACITY;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat(input logic signed [SUM_W-1:0] s,
                                                  input logic signed [SUM_W-1:0] d);
    logic signed [SUM_W:0] r;
    r = {s[SUM_W-1], s} + {d[SUM_W-1], d};
    if (r > $signed({1'b0, SUM_MAX})) return SUM_MAX;
    if (r < $signed({1'b1, SUM_MIN})) return SUM_MIN;
    return r[SUM_W-1:0];
  endfunction

  assign in_ready = (st_r == S_IDLE);
  assign corner = (k_r == 2'd0) ? it_r.index_a[AW-1:0] :
                  (k_r == 2'd1) ? it_r.index_b[AW-1:0] : it_r.index_c[AW-1:0];

  always_comb begin
    pos_re = 1'b0; pos_ra = it_r.index_a[AW-1:0];
    sum_re = 1'b0; sum_we = 1'b0; sum_a = corner; sum_wd = '0;
    nreq = '0;
    nreq.sx = sum_q[3*SUM_W-1:2*SUM_W];
    nreq.sy = sum_q[2*SUM_W-1:SUM_W];
    nreq.sz = sum_q[SUM_W-1:0];
    case (st_r)
      S_CLR: begin sum_we = 1'b1; sum_a = clr_r[AW-1:0]; end
      S_WCL: begin sum_we = 1'b1; sum_a = it_r.index_a[AW-1:0]; end
      S_RA: begin pos_re = 1'b1; pos_ra = it_r.index_a[AW-1:0]; end
      S_RB: begin pos_re = 1'b1; pos_ra = it_r.index_b[AW-1:0]; end
      S_RC: begin pos_re = 1'b1; pos_ra = it_r.index_c[AW-1:0]; end
      S_RD: sum_re = 1'b1;
      S_WR: begin
        sum_we = 1'b1;
        sum_wd = {sat($signed(sum_q[3*SUM_W-1:2*SUM_W]), nx_r),
                  sat($signed(sum_q[2*SUM_W-1:SUM_W]), ny_r),
                  sat($signed(sum_q[SUM_W-1:0]), nz_r)};
      end
      S_RDW: begin
        sum_re = in_rng(it_r.index_a); sum_a = it_r.index_a[AW-1:0];
      end
      S_NRM: begin
        nreq.start = 1'b1;
        if (!in_rng(it_r.index_a)) begin nreq.sx = '0; nreq.sy = '0; nreq.sz = '0; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_re) pos_q <= pos_mem[pos_ra];
    if (sum_re) sum_q <= sum_mem[sum_a];
    if (sum_we) sum_mem[sum_a] <= sum_wd;
    if (st_r == S_IDLE && in_valid && in_data.command == CMD_WRITE &&
        in_rng(in_data.index_a)) begin
      pos_mem[in_data.index_a[AW-1:0]] <= {in_data.pos_x[CW-1:0], in_data.pos_y[CW-1:0],
                                           in_data.pos_z[CW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; out_valid <= 1'b0; k_r <= '0;
    end else begin
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 17'd1;
          if (32'(clr_r) == VERTEX_CAPACITY - 1) st_r <= S_IDLE;
        end
        S_WCL: st_r <= S_IDLE;
        S_IDLE: if (in_valid) begin
          it_r <= in_data;
          k_r <= '0;
          case (in_data.command)
            CMD_WRITE: st_r <= in_rng(in_data.index_a) ? S_WCL : S_IDLE;
            CMD_TRI: st_r <= (in_rng(in_data.index_a) && in_rng(in_data.index_b) &&
                              in_rng(in_data.index_c)) ? S_RA : S_IDLE;
            CMD_READ: st_r <= S_RDW;
            default: st_r <= S_IDLE;
          endcase
        end
        S_RA: st_r <= S_RB;
        S_RB: begin
          {ax_r, ay_r, az_r} <= pos_q; st_r <= S_RC;
        end
        S_RC: begin
          {bx_r, by_r, bz_r} <= pos_q; st_r <= S_SUB;
        end
        S_SUB: begin
          ux_r <= $signed(pos_q[3*CW-1:2*CW]) - ax_r;
          uy_r <= $signed(pos_q[2*CW-1:CW]) - ay_r;
          uz_r <= $signed(pos_q[CW-1:0]) - az_r;
          vx_r <= bx_r - ax_r; vy_r <= by_r - ay_r; vz_r <= bz_r - az_r;
          st_r <= S_MUL;
        end
        S_MUL: begin
          p0_r <= uy_r * vz_r; p1_r <= uz_r * vy_r;
          p2_r <= uz_r * vx_r; p3_r <= ux_r * vz_r;
          p4_r <= ux_r * vy_r; p5_r <= uy_r * vx_r;
          st_r <= S_CRS;
        end
        S_CRS: begin
          nx_r <= SUM_W'(p0_r - p1_r); ny_r <= SUM_W'(p2_r - p3_r);
          nz_r <= SUM_W'(p4_r - p5_r);
          st_r <= S_RD;
        end
        S_RD: st_r <= S_WR;
        S_WR: begin
          k_r <= k_r + 2'd1;
          st_r <= (k_r == 2'd2) ? S_IDLE : S_RD;
        end
        S_RDW: st_r <= S_NRM;
        S_NRM: st_r <= S_OUT;
        S_OUT: begin
          if (ndone) begin out_valid <= 1'b1; out_data <= nres; end
          if (out_valid && out_ready) begin out_valid <= 1'b0; st_r <= S_IDLE; end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  vna_normalize u_norm (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (nreq),
    .done (ndone),
    .res  (nres)
  );

  `VNA_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> !out_valid)
  `VNA_ASSERT(a_out_in_read, clk, rst_n, out_valid |-> st_r == S_OUT)
  `VNA_ASSERT(a_no_dual_sum, clk, rst_n, !(sum_re && sum_we))
endmodule

@@ sim/vertex_normal_checker.sv @@
module vertex_normal_checker import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  longint    vx [1024];
  longint    vy [1024];
  longint    vz [1024];
  longint    acc_x [1024];
  longint    acc_y [1024];
  longint    acc_z [1024];
  out_item_t normal_queue [$];

  function automatic longint sat_sum(longint s, longint d);
    longint r;
    r = s + d;
    if (r > SAT_HI) return SAT_HI;
    if (r < SAT_LO) return SAT_LO;
    return r;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned q);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > q) b = b >> 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q = q - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_part(longint s, longint unsigned t,
                                            longint unsigned len);
    longint unsigned q;
    q = (t * 64'd32768 + len) / (64'd2 * len);
    if (s < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic out_item_t unit_normal(longint sx, longint sy, longint sz);
    out_item_t       r;
    longint unsigned mx, my, mz, m, len;
    int              sh;
    mx = (sx < 0) ? -sx : sx;
    my = (sy < 0) ? -sy : sy;
    mz = (sz < 0) ? -sz : sz;
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    r = '0;
    if (m == 0) begin
      r.zero_sum = 1'b1;
      return r;
    end
    sh = 0;
    if (m >= (64'd1 << 30)) begin
      while ((m >> sh) >= (64'd1 << 30)) sh++;
      mx = mx >> sh;
      my = my >> sh;
      mz = mz >> sh;
    end else begin
      while ((m << sh) < (64'd1 << 29)) sh++;
      mx = mx << sh;
      my = my << sh;
      mz = mz << sh;
    end
    len = root_floor(mx * mx + my * my + mz * mz);
    r.normal_x = unit_part(sx, mx, len);
    r.normal_y = unit_part(sy, my, len);
    r.normal_z = unit_part(sz, mz, len);
    return r;
  endfunction

  task automatic apply_command(in_item_t it);
    longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
    int     a, b, c;
    a = int'(it.index_a);
    b = int'(it.index_b);
    c = int'(it.index_c);
    case (it.command)
      CMD_WRITE: begin
        vx[a] = longint'(it.pos_x);
        vy[a] = longint'(it.pos_y);
        vz[a] = longint'(it.pos_z);
        acc_x[a] = 0;
        acc_y[a] = 0;
        acc_z[a] = 0;
      end
      CMD_TRI: begin
        ux = vx[c] - vx[a];
        uy = vy[c] - vy[a];
        uz = vz[c] - vz[a];
        wx = vx[b] - vx[a];
        wy = vy[b] - vy[a];
        wz = vz[b] - vz[a];
        nx = uy * wz - uz * wy;
        ny = uz * wx - ux * wz;
        nz = ux * wy - uy * wx;
        foreach (acc_x[i]) begin
          if (i == a || i == b || i == c) begin
            repeat ((i == a) + (i == b) + (i == c)) begin
              acc_x[i] = sat_sum(acc_x[i], nx);
              acc_y[i] = sat_sum(acc_y[i], ny);
              acc_z[i] = sat_sum(acc_z[i], nz);
            end
          end
        end
      end
      CMD_READ: normal_queue = {normal_queue, unit_normal(acc_x[a], acc_y[a], acc_z[a])};
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fail_count = 0;
      normal_queue.delete();
      foreach (acc_x[i]) begin
        vx[i] = 0;
        vy[i] = 0;
        vz[i] = 0;
        acc_x[i] = 0;
        acc_y[i] = 0;
        acc_z[i] = 0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (normal_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = normal_queue.pop_front();
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %0d %0d %0d z%0d, got %0d %0d %0d z%0d",
                       want.normal_x, want.normal_y, want.normal_z, want.zero_sum,
                       out_data.normal_x, out_data.normal_y, out_data.normal_z,
                       out_data.zero_sum);
          end
        end
      end
      if (in_valid && in_ready) apply_command(in_data);
    end
    pending = normal_queue.size();
  end
endmodule

@@ sim/vertex_normal_accumulator_test.sv @@
module vertex_normal_accumulator_test;
  import vna_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycles = 0;
  bit        calm = 1'b0;
  bit        hold_request = 1'b0;
  bit        hold_done = 1'b0;
  int        written [$];

  vertex_normal_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  vertex_normal_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[vertex_normal_accumulator] ERROR");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  function automatic in_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic send(in_item_t it);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.command == CMD_WRITE) written = {written, int'(it.index_a)};
  endtask

  task automatic put_vertex(int idx, int x, int y, int z);
    in_item_t it;
    it = random_item();
    it.command = CMD_WRITE;
    it.index_a = IDX_W'(idx);
    it.pos_x = FLD_W'(x);
    it.pos_y = FLD_W'(y);
    it.pos_z = FLD_W'(z);
    send(it);
  endtask

  task automatic put_triangle(int a, int b, int c);
    in_item_t it;
    it = random_item();
    it.command = CMD_TRI;
    it.index_a = IDX_W'(a);
    it.index_b = IDX_W'(b);
    it.index_c = IDX_W'(c);
    send(it);
  endtask

  task automatic ask_normal(int idx);
    in_item_t it;
    it = random_item();
    it.command = CMD_READ;
    it.index_a = IDX_W'(idx);
    send(it);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return $signed(16'($urandom));
      default: return $urandom_range(512) - 256;
    endcase
  endfunction

  function automatic int pick_index();
    if ($urandom_range(9) == 0) return $urandom_range(1023);
    return $urandom_range(31);
  endfunction

  initial begin
    in_item_t junk;
    int       r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    ask_normal(5);
    put_vertex(0, 32767, 32767, 32767);
    put_vertex(1023, -32768, -32768, -32768);
    put_vertex(1, -32768, 32767, 0);
    put_vertex(2, 0, 0, 0);
    put_vertex(3, 1, 0, 0);
    put_vertex(4, 0, 1, 0);
    put_triangle(0, 1023, 1);
    ask_normal(0);
    ask_normal(1023);
    put_triangle(2, 3, 4);
    ask_normal(2);
    put_triangle(2, 2, 3);
    ask_normal(2);
    put_triangle(0, 1023, 0);
    ask_normal(0);
    put_triangle(1, 1, 1);
    ask_normal(1);
    put_vertex(0, 100, -200, 300);
    ask_normal(0);
    junk = random_item();
    junk.command = CMD_UNUSED;
    send(junk);
    ask_normal(4);

    for (int n = 0; n < 1450; n++) begin
      if (n == 600) calm = 1'b1;
      if (n == 800) calm = 1'b0;
      if (n == 1000) hold_request = 1'b1;
      r = $urandom_range(99);
      if (r < 28) begin
        put_vertex(pick_index(), pick_coord(), pick_coord(), pick_coord());
      end else if (r < 68) begin
        put_triangle(written[$urandom_range(written.size() - 1)],
                     written[$urandom_range(written.size() - 1)],
                     written[$urandom_range(written.size() - 1)]);
      end else if (r < 95) begin
        ask_normal(pick_index());
      end else begin
        junk = random_item();
        junk.command = CMD_UNUSED;
        send(junk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("[vertex_normal_accumulator] OK");
    end else begin
      $display("[vertex_normal_accumulator] ERROR");
    end
    $finish;
  end
endmodule
